@@ hdl/chm_pkg.sv @@
// Package: sizes, operation codes and sequencer states for the chained hash map.
`timescale 1ns / 1ps
package chm_pkg;
    localparam int NUM_BUCKETS  = 1024;
    localparam int POOL_ENTRIES = 1024;
    localparam int BUCKET_W = $clog2(NUM_BUCKETS);
    localparam int SLOT_W   = $clog2(POOL_ENTRIES);
    localparam int COUNT_W  = SLOT_W + 1;
    localparam logic [31:0] HASH_SEED = 32'd177573;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HEAD_RD,
        ST_HEAD_WAIT,
        ST_NODE_RD,
        ST_NODE_WAIT,
        ST_CMP,
        ST_FREE_RD,
        ST_FREE_WAIT,
        ST_APPLY,
        ST_OUT
    } t_state;
endpackage

@@ hdl/chained_hash_map.sv @@
// Top level: chained hash map with a sequenced walk over bucket and node memories.
`timescale 1ns / 1ps
// Each transaction is one put, get or remove. The sequencer reads the bucket head, then
// walks the chain node by node through a single read port on the node memory, each node
// passing through NODE_RD, NODE_WAIT and CMP; a put that reuses a freed node also reads
// the free list in FREE_RD and FREE_WAIT. The input stall stays high until the result is
// taken. After reset a clearing pass empties all NUM_BUCKETS bucket heads before the
// first transaction.
module chained_hash_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic signed [31:0] i_key,
    input  logic [30:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_result_value,
    output logic        o_found,
    output logic        o_refused
);
    localparam int BW = chm_pkg::BUCKET_W;
    localparam int SW = chm_pkg::SLOT_W;
    localparam int CW = chm_pkg::COUNT_W;

    logic [SW:0]   mem_head [chm_pkg::NUM_BUCKETS];
    logic [31:0]   mem_key  [chm_pkg::POOL_ENTRIES];
    logic [30:0]   mem_val  [chm_pkg::POOL_ENTRIES];
    logic [SW:0]   mem_next [chm_pkg::POOL_ENTRIES];
    logic [SW-1:0] mem_free [chm_pkg::POOL_ENTRIES];

    chm_pkg::t_state r_state, n_state;
    chm_pkg::t_op    r_op, n_op;
    logic [31:0]   r_key, n_key;
    logic [30:0]   r_val, n_val;
    logic [BW-1:0] r_bkt, n_bkt;
    logic [SW:0]   r_link, n_link;
    logic [SW:0]   r_pred, n_pred;
    logic [SW-1:0] r_slot, n_slot;
    logic [CW-1:0] r_steps, n_steps;
    logic [CW-1:0] r_free_depth, n_free_depth;
    logic [CW-1:0] r_fresh, n_fresh;
    logic [CW-1:0] r_count, n_count;
    logic [BW:0]   r_clr, n_clr;
    logic          r_hit, n_hit;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_res, n_res;
    logic          r_found, n_found;
    logic          r_refused, n_refused;

    logic [SW:0]   r_head_q, r_next_q;
    logic [31:0]   r_key_q;
    logic [30:0]   r_val_q;
    logic [SW-1:0] r_free_q;

    logic          head_we, key_we, val_we, next_we, free_we;
    logic [BW-1:0] head_wa;
    logic [SW:0]   head_wd, next_wd;
    logic [SW-1:0] node_wa, next_wa, node_ra;
    logic [SW-1:0] free_wa, free_ra;
    logic [CW-1:0] free_dec;
    logic [31:0]   hash;

    assign hash     = chm_pkg::HASH_SEED + 32'(i_key);
    assign free_dec = r_free_depth - CW'(1);
    assign free_ra  = free_dec[SW-1:0];
    assign node_ra  = r_link[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (head_we) mem_head[head_wa] <= head_wd;
        if (key_we)  mem_key[node_wa]  <= r_key;
        if (val_we)  mem_val[node_wa]  <= r_val;
        if (next_we) mem_next[next_wa] <= next_wd;
        if (free_we) mem_free[free_wa] <= r_slot;
        r_head_q <= mem_head[r_bkt];
        r_key_q  <= mem_key[node_ra];
        r_val_q  <= mem_val[node_ra];
        r_next_q <= mem_next[node_ra];
        r_free_q <= mem_free[free_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= chm_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_free_depth <= '0;
            r_fresh      <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_free_depth <= n_free_depth;
            r_fresh      <= n_fresh;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
        end
        r_op      <= n_op;
        r_key     <= n_key;
        r_val     <= n_val;
        r_bkt     <= n_bkt;
        r_link    <= n_link;
        r_pred    <= n_pred;
        r_slot    <= n_slot;
        r_steps   <= n_steps;
        r_hit     <= n_hit;
        r_res     <= n_res;
        r_found   <= n_found;
        r_refused <= n_refused;
    end

    always_comb begin
        n_state = r_state;     n_op = r_op;       n_key = r_key;   n_val = r_val;
        n_bkt = r_bkt;         n_link = r_link;   n_pred = r_pred; n_slot = r_slot;
        n_steps = r_steps;     n_free_depth = r_free_depth;        n_fresh = r_fresh;
        n_count = r_count;     n_clr = r_clr;     n_hit = r_hit;
        n_out_valid = r_out_valid;  n_res = r_res; n_found = r_found;
        n_refused = r_refused;
        head_we = 1'b0; head_wa = r_bkt; head_wd = '0;
        key_we = 1'b0;  val_we = 1'b0;   node_wa = r_slot;
        next_we = 1'b0; next_wa = r_slot; next_wd = '0;
        free_we = 1'b0; free_wa = r_free_depth[SW-1:0];
        o_stall = 1'b1;
        unique case (r_state)
            chm_pkg::ST_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_clr[BW-1:0];
                n_clr   = r_clr + (BW+1)'(1);
                if (r_clr[BW-1:0] == '1) n_state = chm_pkg::ST_IDLE;
            end
            chm_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_op    = chm_pkg::t_op'(i_kind);
                    n_key   = 32'(i_key);
                    n_val   = i_value;
                    n_bkt   = hash[BW-1:0];
                    n_pred  = '0;
                    n_steps = '0;
                    n_hit   = 1'b0;
                    n_state = chm_pkg::ST_HEAD_RD;
                end
            end
            chm_pkg::ST_HEAD_RD:   n_state = chm_pkg::ST_HEAD_WAIT;
            chm_pkg::ST_HEAD_WAIT: begin
                n_link  = r_head_q;
                n_state = (r_op == chm_pkg::OP_NONE) ? chm_pkg::ST_APPLY
                                                     : chm_pkg::ST_NODE_RD;
            end
            chm_pkg::ST_NODE_RD: begin
                if (r_link[SW] && r_steps < CW'(chm_pkg::POOL_ENTRIES))
                    n_state = chm_pkg::ST_NODE_WAIT;
                else if (r_op == chm_pkg::OP_PUT &&
                         r_count < CW'(chm_pkg::POOL_ENTRIES) && r_free_depth != '0)
                    n_state = chm_pkg::ST_FREE_RD;
                else begin
                    if (r_op == chm_pkg::OP_PUT && r_count < CW'(chm_pkg::POOL_ENTRIES)) begin
                        n_slot  = r_fresh[SW-1:0];
                        n_fresh = r_fresh + CW'(1);
                    end
                    n_state = chm_pkg::ST_APPLY;
                end
            end
            chm_pkg::ST_NODE_WAIT: n_state = chm_pkg::ST_CMP;
            chm_pkg::ST_CMP: begin
                if (r_key_q == r_key) begin
                    n_hit   = 1'b1;
                    n_slot  = r_link[SW-1:0];
                    n_state = chm_pkg::ST_APPLY;
                end else begin
                    n_pred  = r_link;
                    n_link  = r_next_q;
                    n_steps = r_steps + CW'(1);
                    n_state = chm_pkg::ST_NODE_RD;
                end
            end
            chm_pkg::ST_FREE_RD:   n_state = chm_pkg::ST_FREE_WAIT;
            chm_pkg::ST_FREE_WAIT: begin
                n_free_depth = free_dec;
                n_slot       = r_free_q;
                n_state      = chm_pkg::ST_APPLY;
            end
            chm_pkg::ST_APPLY: begin
                n_res     = '1;
                n_found   = r_hit;
                n_refused = 1'b0;
                n_state   = chm_pkg::ST_OUT;
                n_out_valid = 1'b1;
                case (r_op)
                    chm_pkg::OP_PUT: begin
                        if (r_hit) begin
                            val_we = 1'b1;
                        end else if (r_count >= CW'(chm_pkg::POOL_ENTRIES)) begin
                            n_refused = 1'b1;
                        end else begin
                            key_we = 1'b1; val_we = 1'b1; next_we = 1'b1;
                            next_wd = r_head_q;
                            head_we = 1'b1;
                            head_wd = {1'b1, r_slot};
                            n_count = r_count + CW'(1);
                        end
                    end
                    chm_pkg::OP_GET: begin
                        if (r_hit) n_res = {1'b0, r_val_q};
                    end
                    chm_pkg::OP_REMOVE: begin
                        if (r_hit) begin
                            if (r_pred[SW]) begin
                                next_we = 1'b1;
                                next_wa = r_pred[SW-1:0];
                                next_wd = r_next_q;
                            end else begin
                                head_we = 1'b1;
                                head_wd = r_next_q;
                            end
                            if (r_free_depth < CW'(chm_pkg::POOL_ENTRIES)) begin
                                free_we = 1'b1;
                                n_free_depth = r_free_depth + CW'(1);
                            end
                            if (r_count != '0) n_count = r_count - CW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            chm_pkg::ST_OUT: begin
                if (!i_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = chm_pkg::ST_IDLE;
                end
            end
            default: n_state = chm_pkg::ST_IDLE;
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_res;
    assign o_found        = r_found;
    assign o_refused      = r_refused;

    a_out_in_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == chm_pkg::ST_OUT)
        else $error("result shown outside output state");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(chm_pkg::POOL_ENTRIES))
        else $error("entry count beyond pool");
    a_refused_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_refused && o_found))
        else $error("refused and found together");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != chm_pkg::ST_IDLE |-> o_stall)
        else $error("accepting while busy");
endmodule
